// ----- sv/rvr_pkg.sv -----
package rvr_pkg;

    typedef struct packed {
        logic [63:0] raw_element;
        logic        start_volume;
    } t_in;

    typedef struct packed {
        logic [31:0]        voxel_value;
        logic signed [63:0] byte_displacement;
    } t_out;

    typedef enum logic [2:0] {
        REG_ELEMENT_FORMAT = 3'd0,
        REG_SCALE_BITS     = 3'd1,
        REG_OFFSET_BITS    = 3'd2,
        REG_ROW_LENGTH     = 3'd3,
        REG_ROWS_PER_SLICE = 3'd4,
        REG_STRIDE_X       = 3'd5,
        REG_STRIDE_Y       = 3'd6,
        REG_STRIDE_Z       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [3:0]         element_format;
        logic [63:0]        scale_bits;
        logic [63:0]        offset_bits;
        logic [15:0]        row_length;
        logic [15:0]        rows_per_slice;
        logic signed [31:0] stride_x;
        logic signed [31:0] stride_y;
        logic signed [31:0] stride_z;
    } t_cfg;

    // queue entry: decoded double and displacement
    typedef struct packed {
        logic [63:0] value;
        logic [63:0] disp;
    } t_q;

    localparam int SIG_W = 106;

    // value = sig * 2^(exp - bias - 105); sp overrides with sp_bits
    typedef struct packed {
        logic               sp;
        logic [63:0]        sp_bits;
        logic               zsign;
        logic               sign;
        logic signed [13:0] exp;
        logic [SIG_W-1:0]   sig;
        logic               sticky;
    } t_unr;

    localparam logic [3:0] FMT_U8  = 4'd0;
    localparam logic [3:0] FMT_U16 = 4'd1;
    localparam logic [3:0] FMT_U32 = 4'd2;
    localparam logic [3:0] FMT_U64 = 4'd3;
    localparam logic [3:0] FMT_S8  = 4'd4;
    localparam logic [3:0] FMT_S16 = 4'd5;
    localparam logic [3:0] FMT_S32 = 4'd6;
    localparam logic [3:0] FMT_S64 = 4'd7;
    localparam logic [3:0] FMT_F32 = 4'd8;
    localparam logic [3:0] FMT_F64 = 4'd9;

    localparam logic [63:0] DBL_QUIET   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DBL_DEF_NAN = 64'hFFF8_0000_0000_0000;

    function automatic t_unr nrm_step(input t_unr u, input int k);
        t_unr r;
        r = u;
        if ((u.sig >> (SIG_W - k)) == '0) begin
            r.sig = u.sig << k;
            r.exp = u.exp - 14'(k);
        end
        return r;
    endfunction

    function automatic t_unr nrm_denorm(input t_unr u);
        t_unr       r;
        logic [13:0] amt;
        logic [6:0]  sh;
        r   = u;
        amt = 14'd1 - $unsigned(u.exp);
        sh  = amt[6:0];
        if (u.exp <= 14'sd0) begin
            if (amt > 14'd106) begin
                r.sticky = u.sticky | (|u.sig);
                r.sig    = '0;
            end else begin
                r.sticky = u.sticky | (|(u.sig & ~({SIG_W{1'b1}} << sh)));
                r.sig    = u.sig >> sh;
            end
            r.exp = 14'sd1;
        end
        return r;
    endfunction

    function automatic logic [63:0] nrm_round(input t_unr u, input logic single);
        logic [52:0] kd;
        logic        gd;
        logic        sd;
        logic        inc_d;
        logic [63:0] rd;
        logic [23:0] ks;
        logic        gs;
        logic        ss;
        logic        inc_s;
        logic [31:0] rs;
        logic [63:0] res;
        kd    = u.sig[105:53];
        gd    = u.sig[52];
        sd    = (|u.sig[51:0]) | u.sticky;
        inc_d = gd & (sd | kd[0]);
        rd    = {u.sign, (kd[52] ? u.exp[10:0] : 11'd0), kd[51:0]} + 64'(inc_d);
        if (u.exp >= 14'sd2047) begin
            rd = {u.sign, 11'h7FF, 52'd0};
        end
        ks    = u.sig[105:82];
        gs    = u.sig[81];
        ss    = (|u.sig[80:0]) | u.sticky;
        inc_s = gs & (ss | ks[0]);
        rs    = {u.sign, (ks[23] ? u.exp[7:0] : 8'd0), ks[22:0]} + 32'(inc_s);
        if (u.exp >= 14'sd255) begin
            rs = {u.sign, 8'hFF, 23'd0};
        end
        res = single ? {32'd0, rs} : rd;
        if (u.sig == '0 && !u.sticky) begin
            res = single ? {32'd0, u.zsign, 31'd0} : {u.zsign, 63'd0};
        end
        if (u.sp) begin
            res = u.sp_bits;
        end
        return res;
    endfunction

endpackage

// ----- sv/rvr_nrm.sv -----
module rvr_nrm import rvr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_unr        i_unr,
    input  logic        i_single,
    output logic        o_valid,
    output logic [63:0] o_bits
);

    logic [4:0]  r_vld;
    t_unr        r_s1;
    t_unr        r_s2;
    t_unr        r_s3;
    t_unr        r_s4;
    logic [63:0] r_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // leading-zero search in steps, then subnormal shift, then round/pack
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= nrm_step(nrm_step(i_unr, 64), 32);
            r_s2   <= nrm_step(nrm_step(nrm_step(r_s1, 16), 8), 4);
            r_s3   <= nrm_step(nrm_step(r_s2, 2), 1);
            r_s4   <= nrm_denorm(r_s3);
            r_bits <= nrm_round(r_s4, i_single);
        end
    end

    assign o_valid = r_vld[4];
    assign o_bits  = r_bits;

endmodule

// ----- sv/rvr_fifo.sv -----
module rvr_fifo import rvr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_q   i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_q   o_pop_data,
    output logic o_empty
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_q            r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd];
    assign o_full     = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty    = (r_cnt == '0);

endmodule

// ----- sv/rvr_front.sv -----
module rvr_front import rvr_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_push,
    output t_q   o_push_data,
    input  logic i_full
);

    localparam int CW = COUNT_WIDTH;
    localparam int PW = CW + 33;

    logic          en;
    logic          acc;
    logic          nrm_valid;
    logic [63:0]   nrm_bits;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] r_slc;
    logic [CW-1:0] cur_c;
    logic [CW-1:0] cur_r;
    logic [CW-1:0] cur_s;
    logic [CW-1:0] c1;
    logic [CW-1:0] rw1;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [CW-1:0] n_slc;

    logic          r_v0;
    t_unr          r_unr0;
    logic [CW-1:0] r_c0;
    logic [CW-1:0] r_r0;
    logic [CW-1:0] r_s0;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] r_pz;
    logic [63:0]   r_dl [4];

    logic [63:0]   raw;
    logic [63:0]   mag_u;
    logic [63:0]   sx;
    logic [63:0]   mag_s;
    logic [7:0]    fe;
    t_unr          dec;

    assign en         = !nrm_valid || !i_full;
    assign o_in_ready = en;
    assign acc        = i_in_valid && en;

    // column / row / slice counters
    always_comb begin
        cur_c = i_in_data.start_volume ? '0 : r_col;
        cur_r = i_in_data.start_volume ? '0 : r_row;
        cur_s = i_in_data.start_volume ? '0 : r_slc;
        c1    = cur_c + 1'b1;
        rw1   = cur_r + 1'b1;
        n_col = c1;
        n_row = cur_r;
        n_slc = cur_s;
        if (c1 == '0 || 32'(c1) >= 32'(i_cfg.row_length)) begin
            n_col = '0;
            n_row = rw1;
            if (rw1 == '0 || 32'(rw1) >= 32'(i_cfg.rows_per_slice)) begin
                n_row = '0;
                n_slc = cur_s + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_slc <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_slc <= n_slc;
        end
    end

    // element decode
    always_comb begin
        raw = i_in_data.raw_element;
        fe  = raw[30:23];
        case (i_cfg.element_format[1:0])
            2'd0: begin
                mag_u = {56'd0, raw[7:0]};
                sx    = {{56{raw[7]}}, raw[7:0]};
            end
            2'd1: begin
                mag_u = {48'd0, raw[15:0]};
                sx    = {{48{raw[15]}}, raw[15:0]};
            end
            2'd2: begin
                mag_u = {32'd0, raw[31:0]};
                sx    = {{32{raw[31]}}, raw[31:0]};
            end
            default: begin
                mag_u = raw;
                sx    = raw;
            end
        endcase
        mag_s = sx[63] ? (~sx + 64'd1) : sx;

        dec     = '0;
        dec.exp = 14'sd1086;
        case (i_cfg.element_format)
            FMT_U8, FMT_U16, FMT_U32, FMT_U64: begin
                dec.sig = {mag_u, 42'd0};
            end
            FMT_S8, FMT_S16, FMT_S32, FMT_S64: begin
                dec.sign = sx[63];
                dec.sig  = {mag_s, 42'd0};
            end
            FMT_F32: begin
                if (fe == 8'hFF) begin
                    dec.sp      = 1'b1;
                    dec.sp_bits = {raw[31], 11'h7FF, raw[22:0], 29'd0}
                                | ((raw[22:0] != '0) ? DBL_QUIET : 64'd0);
                end else begin
                    dec.sign  = raw[31];
                    dec.zsign = raw[31];
                    dec.sig   = {64'({fe != 8'd0, raw[22:0]}), 42'd0};
                    dec.exp   = 14'((fe == 8'd0) ? 8'd1 : fe) + 14'd936;
                end
            end
            FMT_F64: begin
                dec.sp      = 1'b1;
                dec.sp_bits = raw;
            end
            default: begin
                dec.sp      = 1'b1;
                dec.sp_bits = 64'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_unr0   <= dec;
            r_c0     <= cur_c;
            r_r0     <= cur_r;
            r_s0     <= cur_s;
            r_px     <= $signed({1'b0, r_c0}) * i_cfg.stride_x;
            r_py     <= $signed({1'b0, r_r0}) * i_cfg.stride_y;
            r_pz     <= $signed({1'b0, r_s0}) * i_cfg.stride_z;
            r_dl[0]  <= 64'(r_px) + 64'(r_py) + 64'(r_pz);
            r_dl[1]  <= r_dl[0];
            r_dl[2]  <= r_dl[1];
            r_dl[3]  <= r_dl[2];
        end
    end

    rvr_nrm u_nrm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v0),
        .i_unr    (r_unr0),
        .i_single (1'b0),
        .o_valid  (nrm_valid),
        .o_bits   (nrm_bits)
    );

    assign o_push            = nrm_valid && !i_full;
    assign o_push_data.value = nrm_bits;
    assign o_push_data.disp  = r_dl[3];

endmodule

// ----- sv/rvr_back.sv -----
module rvr_back import rvr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_empty,
    output logic o_pop,
    input  t_q   i_pop_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int DLY = 20;

    logic        en;
    logic        pop;

    // multiply operands
    logic [63:0] ma_bits;
    logic [63:0] mb_bits;
    logic [10:0] ea;
    logic [10:0] eb;
    logic [52:0] ma;
    logic [52:0] mb;
    logic        a_nan, a_inf, a_zero;
    logic        b_nan, b_inf, b_zero;
    logic        m_sign;
    logic        m_sp;
    logic [63:0] m_spb;

    logic        r_v1;
    logic [51:0] r_hh;
    logic [52:0] r_hl;
    logic [52:0] r_lh;
    logic [53:0] r_ll;
    logic signed [13:0] r1_exp;
    logic        r1_sign;
    logic        r1_sp;
    logic [63:0] r1_spb;

    logic        r_v2;
    t_unr        r_u2;

    logic        p_valid;
    logic [63:0] p_bits;

    // add operands
    logic [63:0] aa;
    logic [63:0] ab;
    logic        a_big;
    logic [63:0] big;
    logic [63:0] sml;
    logic [10:0] ebg;
    logic [10:0] esm;
    logic [10:0] ebe;
    logic [10:0] ese;
    logic [10:0] dsh;
    logic [55:0] sme;
    logic [55:0] aln;
    logic        aa_nan, aa_inf, ab_nan, ab_inf;
    logic        s_sp;
    logic [63:0] s_spb;

    logic        r_v8;
    logic [55:0] r8_big;
    logic [55:0] r8_aln;
    logic        r8_sub;
    logic        r8_sign;
    logic        r8_zs;
    logic [10:0] r8_exp;
    logic        r8_sp;
    logic [63:0] r8_spb;

    logic [56:0] sum;
    logic        r_v9;
    t_unr        r_u9;

    logic        r_valid;
    logic [63:0] r_bits;

    t_unr        cv;
    logic        r_v15;
    t_unr        r_u15;

    logic        o_valid3;
    logic [63:0] o_bits3;

    logic [63:0] r_dl [DLY];

    assign en    = !o_valid3 || i_out_ready;
    assign pop   = en && !i_empty;
    assign o_pop = pop;

    // stage 1: unpack, partial products
    always_comb begin
        ma_bits = i_pop_data.value;
        mb_bits = i_cfg.scale_bits;
        ea      = ma_bits[62:52];
        eb      = mb_bits[62:52];
        ma      = {ea != 11'd0, ma_bits[51:0]};
        mb      = {eb != 11'd0, mb_bits[51:0]};
        a_nan   = (ea == 11'h7FF) && (ma_bits[51:0] != '0);
        a_inf   = (ea == 11'h7FF) && (ma_bits[51:0] == '0);
        a_zero  = (ea == 11'd0) && (ma_bits[51:0] == '0);
        b_nan   = (eb == 11'h7FF) && (mb_bits[51:0] != '0);
        b_inf   = (eb == 11'h7FF) && (mb_bits[51:0] == '0);
        b_zero  = (eb == 11'd0) && (mb_bits[51:0] == '0);
        m_sign  = ma_bits[63] ^ mb_bits[63];
        m_sp    = 1'b1;
        m_spb   = 64'd0;
        if (a_nan) begin
            m_spb = ma_bits | DBL_QUIET;
        end else if (b_nan) begin
            m_spb = mb_bits | DBL_QUIET;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            m_spb = DBL_DEF_NAN;
        end else if (a_inf || b_inf) begin
            m_spb = {m_sign, 11'h7FF, 52'd0};
        end else if (a_zero || b_zero) begin
            m_spb = {m_sign, 63'd0};
        end else begin
            m_sp = 1'b0;
        end
    end

    // add alignment
    always_comb begin
        aa     = p_bits;
        ab     = i_cfg.offset_bits;
        aa_nan = (aa[62:52] == 11'h7FF) && (aa[51:0] != '0);
        aa_inf = (aa[62:52] == 11'h7FF) && (aa[51:0] == '0);
        ab_nan = (ab[62:52] == 11'h7FF) && (ab[51:0] != '0);
        ab_inf = (ab[62:52] == 11'h7FF) && (ab[51:0] == '0);
        a_big  = aa[62:0] >= ab[62:0];
        big    = a_big ? aa : ab;
        sml    = a_big ? ab : aa;
        ebg    = big[62:52];
        esm    = sml[62:52];
        ebe    = (ebg == 11'd0) ? 11'd1 : ebg;
        ese    = (esm == 11'd0) ? 11'd1 : esm;
        dsh    = ebe - ese;
        sme    = {esm != 11'd0, sml[51:0], 3'd0};
        if (dsh >= 11'd56) begin
            aln = {55'd0, |sme};
        end else begin
            aln = (sme >> dsh[5:0])
                | 56'(|(sme & ~({56{1'b1}} << dsh[5:0])));
        end
        s_sp  = 1'b1;
        s_spb = 64'd0;
        if (aa_nan) begin
            s_spb = aa | DBL_QUIET;
        end else if (ab_nan) begin
            s_spb = ab | DBL_QUIET;
        end else if (aa_inf && ab_inf && (aa[63] != ab[63])) begin
            s_spb = DBL_DEF_NAN;
        end else if (aa_inf) begin
            s_spb = aa;
        end else if (ab_inf) begin
            s_spb = ab;
        end else begin
            s_sp = 1'b0;
        end
    end

    assign sum = r8_sub ? ({1'b0, r8_big} - {1'b0, r8_aln})
                        : ({1'b0, r8_big} + {1'b0, r8_aln});

    // double to single unpack
    always_comb begin
        cv = '0;
        if (r_bits[62:52] == 11'h7FF) begin
            cv.sp = 1'b1;
            if (r_bits[51:0] != '0) begin
                cv.sp_bits = {32'd0, r_bits[63], 8'hFF, 1'b1, r_bits[50:29]};
            end else begin
                cv.sp_bits = {32'd0, r_bits[63], 8'hFF, 23'd0};
            end
        end else begin
            cv.sign  = r_bits[63];
            cv.zsign = r_bits[63];
            cv.sig   = {r_bits[62:52] != 11'd0, r_bits[51:0], 53'd0};
            cv.exp   = 14'((r_bits[62:52] == 11'd0) ? 11'd1 : r_bits[62:52]) - 14'd896;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v15 <= 1'b0;
        end else if (en) begin
            r_v1  <= pop;
            r_v2  <= r_v1;
            r_v8  <= p_valid;
            r_v9  <= r_v8;
            r_v15 <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hh    <= ma[52:27] * mb[52:27];
            r_hl    <= ma[52:27] * mb[26:0];
            r_lh    <= ma[26:0] * mb[52:27];
            r_ll    <= ma[26:0] * mb[26:0];
            r1_exp  <= 14'((ea == 11'd0) ? 11'd1 : ea)
                     + 14'((eb == 11'd0) ? 11'd1 : eb) - 14'd1022;
            r1_sign <= m_sign;
            r1_sp   <= m_sp;
            r1_spb  <= m_spb;

            r_u2.sp      <= r1_sp;
            r_u2.sp_bits <= r1_spb;
            r_u2.zsign   <= r1_sign;
            r_u2.sign    <= r1_sign;
            r_u2.exp     <= r1_exp;
            r_u2.sig     <= (106'(r_hh) << 54) + (106'(r_hl) << 27)
                          + (106'(r_lh) << 27) + 106'(r_ll);
            r_u2.sticky  <= 1'b0;

            r8_big  <= {ebg != 11'd0, big[51:0], 3'd0};
            r8_aln  <= aln;
            r8_sub  <= aa[63] ^ ab[63];
            r8_sign <= big[63];
            r8_zs   <= aa[63] & ab[63];
            r8_exp  <= ebe;
            r8_sp   <= s_sp;
            r8_spb  <= s_spb;

            r_u9.sp      <= r8_sp;
            r_u9.sp_bits <= r8_spb;
            r_u9.zsign   <= r8_zs;
            r_u9.sign    <= r8_sign;
            r_u9.exp     <= 14'(r8_exp) + 14'd1;
            r_u9.sig     <= {sum, 49'd0};
            r_u9.sticky  <= 1'b0;

            r_u15 <= cv;

            r_dl[0] <= i_pop_data.disp;
            for (int i = 1; i < DLY; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    rvr_nrm u_nrm_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v2),
        .i_unr    (r_u2),
        .i_single (1'b0),
        .o_valid  (p_valid),
        .o_bits   (p_bits)
    );

    rvr_nrm u_nrm_add (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v9),
        .i_unr    (r_u9),
        .i_single (1'b0),
        .o_valid  (r_valid),
        .o_bits   (r_bits)
    );

    rvr_nrm u_nrm_sgl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v15),
        .i_unr    (r_u15),
        .i_single (1'b1),
        .o_valid  (o_valid3),
        .o_bits   (o_bits3)
    );

    assign o_out_valid                  = o_valid3;
    assign o_out_data.voxel_value       = o_bits3[31:0];
    assign o_out_data.byte_displacement = r_dl[DLY-1];

endmodule

// ----- sv/raw_voxel_rescale_strided.sv -----
// channel   dir  handshake              word
// in        in   i_in_valid/o_in_ready  t_in  (raw_element, start_volume)
// out       out  o_out_valid/i_out_ready t_out (voxel_value, byte_displacement)
// cfg       in   i_cfg_we               i_cfg_index, i_cfg_data
//
// One word per cycle sustained unless the output holds off ready; a word passes
// through the decode front, then the queue, then the multiply/add/round back end.
// Front and back each stall as a whole; the 4-entry queue decouples them.
// Synchronous reset clears counters, valids and config to defaults.
module raw_voxel_rescale_strided import rvr_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    logic push;
    t_q   push_data;
    logic full;
    logic pop;
    t_q   pop_data;
    logic empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.element_format <= FMT_U8;
            r_cfg.scale_bits     <= 64'h3FF0_0000_0000_0000;
            r_cfg.offset_bits    <= 64'd0;
            r_cfg.row_length     <= 16'd1;
            r_cfg.rows_per_slice <= 16'd1;
            r_cfg.stride_x       <= 32'sd4;
            r_cfg.stride_y       <= 32'sd0;
            r_cfg.stride_z       <= 32'sd0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ELEMENT_FORMAT: r_cfg.element_format <= i_cfg_data[3:0];
                REG_SCALE_BITS:     r_cfg.scale_bits     <= i_cfg_data;
                REG_OFFSET_BITS:    r_cfg.offset_bits    <= i_cfg_data;
                REG_ROW_LENGTH:     r_cfg.row_length     <= i_cfg_data[15:0];
                REG_ROWS_PER_SLICE: r_cfg.rows_per_slice <= i_cfg_data[15:0];
                REG_STRIDE_X:       r_cfg.stride_x       <= i_cfg_data[31:0];
                REG_STRIDE_Y:       r_cfg.stride_y       <= i_cfg_data[31:0];
                REG_STRIDE_Z:       r_cfg.stride_z       <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    rvr_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    rvr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    rvr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rvr_pkg::*;

    localparam int LIMIT = 600000;
    localparam int DRAIN = 40;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    class rescale_scoreboard;
        t_cfg        cfg;
        logic [15:0] col, row, slc;
        t_out        pending_q[$];
        int          errors;
        int          checked;

        function void reset_state();
            cfg.element_format = FMT_U8;
            cfg.scale_bits     = 64'h3FF0_0000_0000_0000;
            cfg.offset_bits    = '0;
            cfg.row_length     = 16'd1;
            cfg.rows_per_slice = 16'd1;
            cfg.stride_x       = 32'sd4;
            cfg.stride_y       = '0;
            cfg.stride_z       = '0;
            col = '0;
            row = '0;
            slc = '0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] d);
            case (idx)
                REG_ELEMENT_FORMAT: cfg.element_format = d[3:0];
                REG_SCALE_BITS:     cfg.scale_bits = d;
                REG_OFFSET_BITS:    cfg.offset_bits = d;
                REG_ROW_LENGTH:     cfg.row_length = d[15:0];
                REG_ROWS_PER_SLICE: cfg.rows_per_slice = d[15:0];
                REG_STRIDE_X:       cfg.stride_x = d[31:0];
                REG_STRIDE_Y:       cfg.stride_y = d[31:0];
                default:            cfg.stride_z = d[31:0];
            endcase
        endfunction

        function bit is_nan(logic [63:0] d);
            return d[62:52] == 11'h7FF && d[51:0] != '0;
        endfunction

        function bit is_inf(logic [63:0] d);
            return d[62:52] == 11'h7FF && d[51:0] == '0;
        endfunction

        function bit is_zero(logic [63:0] d);
            return d[62:0] == '0;
        endfunction

        function logic [63:0] u64_to_dbl(logic [63:0] u);
            real hi, lo;
            hi = real'(longint'({32'd0, u[63:32]}));
            lo = real'(longint'({32'd0, u[31:0]}));
            return $realtobits(hi * 4294967296.0 + lo);
        endfunction

        function logic [63:0] f32_to_dbl(logic [31:0] f);
            logic [10:0] e;
            real         v;
            if (f[30:23] == 8'hFF)
                return {f[31], 11'h7FF, f[22], f[21:0], 29'd0} |
                       (f[22:0] != '0 ? QUIET_BIT : 64'd0);
            if (f[30:23] == 8'd0) begin
                v = real'(longint'({41'd0, f[22:0]})) * (2.0 ** -149);
                if (f[31])
                    v = -v;
                return $realtobits(v);
            end
            e = 11'(f[30:23]) + 11'd896;
            return {f[31], e, f[22:0], 29'd0};
        endfunction

        function logic [63:0] decode(logic [63:0] raw);
            logic [63:0] sx;
            logic [63:0] d;
            case (cfg.element_format)
                FMT_U8:  return u64_to_dbl({56'd0, raw[7:0]});
                FMT_U16: return u64_to_dbl({48'd0, raw[15:0]});
                FMT_U32: return u64_to_dbl({32'd0, raw[31:0]});
                FMT_U64: return u64_to_dbl(raw);
                FMT_S8, FMT_S16, FMT_S32, FMT_S64: begin
                    case (cfg.element_format)
                        FMT_S8:  sx = {{56{raw[7]}}, raw[7:0]};
                        FMT_S16: sx = {{48{raw[15]}}, raw[15:0]};
                        FMT_S32: sx = {{32{raw[31]}}, raw[31:0]};
                        default: sx = raw;
                    endcase
                    if (!sx[63])
                        return u64_to_dbl(sx);
                    d = u64_to_dbl(-sx);
                    return {1'b1, d[62:0]};
                end
                FMT_F32: return f32_to_dbl(raw[31:0]);
                FMT_F64: return raw;
                default: return 64'd0;
            endcase
        endfunction

        function logic [63:0] dbl_mul(logic [63:0] a, logic [63:0] b);
            if (is_nan(a)) return a | QUIET_BIT;
            if (is_nan(b)) return b | QUIET_BIT;
            if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return DEFAULT_NAN;
            return $realtobits($bitstoreal(a) * $bitstoreal(b));
        endfunction

        function logic [63:0] dbl_add(logic [63:0] a, logic [63:0] b);
            if (is_nan(a)) return a | QUIET_BIT;
            if (is_nan(b)) return b | QUIET_BIT;
            if (is_inf(a) && is_inf(b) && a[63] != b[63]) return DEFAULT_NAN;
            return $realtobits($bitstoreal(a) + $bitstoreal(b));
        endfunction

        function logic [31:0] to_single(logic [63:0] d);
            logic [52:0] mant;
            logic [52:0] kept;
            int          es, sh;
            logic        g, st;
            logic [31:0] base;
            if (d[62:52] == 11'h7FF)
                return d[51:0] == '0 ? {d[63], 8'hFF, 23'd0}
                                     : {d[63], 8'hFF, 1'b1, d[50:29]};
            if (d[62:52] == 11'd0)
                return {d[63], 31'd0};
            mant = {1'b1, d[51:0]};
            es = int'(d[62:52]) - 1023 + 127;
            if (es >= 255)
                return {d[63], 8'hFF, 23'd0};
            if (es >= 1) begin
                sh = 29;
                base = {d[63], 8'(es), 23'd0};
            end else begin
                sh = 29 + 1 - es;
                base = {d[63], 31'd0};
            end
            // below half of the smallest subnormal
            if (sh > 53)
                return {d[63], 31'd0};
            kept = mant >> sh;
            g = mant[sh - 1];
            st = (mant & ((53'd1 << (sh - 1)) - 53'd1)) != '0;
            if (es >= 1)
                kept[23] = 1'b0;
            return base + 32'(kept) + 32'(g & (st | kept[0]));
        endfunction

        function void note(t_in w);
            t_out e;
            logic [63:0] p;
            if (w.start_volume) begin
                col = '0;
                row = '0;
                slc = '0;
            end
            p = dbl_mul(decode(w.raw_element), cfg.scale_bits);
            e.voxel_value = to_single(dbl_add(p, cfg.offset_bits));
            e.byte_displacement = longint'({48'd0, col}) * longint'(cfg.stride_x)
                                + longint'({48'd0, row}) * longint'(cfg.stride_y)
                                + longint'({48'd0, slc}) * longint'(cfg.stride_z);
            pending_q.insert(pending_q.size(), e);
            col = col + 16'd1;
            if (col >= cfg.row_length || col == '0) begin
                col = '0;
                row = row + 16'd1;
                if (row >= cfg.rows_per_slice || row == '0) begin
                    row = '0;
                    slc = slc + 16'd1;
                end
            end
        endfunction

        function void check(t_out got);
            t_out e;
            checked++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %h %h", got.voxel_value,
                             got.byte_displacement);
                return;
            end
            e = pending_q.pop_front();
            if (got.voxel_value !== e.voxel_value ||
                got.byte_displacement !== e.byte_displacement) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp value %h disp %h, got value %h disp %h",
                             e.voxel_value, e.byte_displacement,
                             got.voxel_value, got.byte_displacement);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    rescale_scoreboard sb = new();
    int cycles = 0;
    int settings = 0;
    int stall_mode = 0;
    int stall_phase = 0;

    raw_voxel_rescale_strided uut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check(o_out_data);

    // receiver: ready pattern drawn at random from four modes and redrawn periodically
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= (stall_phase % 7) < 3;
            default: i_out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic wait_idle();
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] d);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(t_in w);
        i_in_valid = 1'b1;
        i_in_data = w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note(w);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        i_in_valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_double();
        case ($urandom_range(0, 11))
            0: return 64'h3FF0_0000_0000_0000;
            1: return 64'hBFF0_0000_0000_0000;
            2: return {$urandom_range(0, 1) == 1, 63'd0};
            3: return 64'h7FF0_0000_0000_0000 | {$urandom_range(0, 1) == 1, 63'd0};
            4: return {1'($urandom), 11'h7FF, 20'($urandom) | 20'd1, 32'($urandom)};
            5: return {1'($urandom), 11'($urandom_range(1000, 1100)),
                       20'($urandom), 32'($urandom)};
            6: return {1'($urandom), 11'($urandom_range(1150, 1200)),
                       20'($urandom), 32'($urandom)};
            7: return {1'($urandom), 11'($urandom_range(850, 900)),
                       20'($urandom), 32'($urandom)};
            8: return {1'($urandom), 11'd0, 20'($urandom), 32'($urandom)};
            9: return {1'($urandom), 11'h7FE, 52'hF_FFFF_FFFF_FFFF};
            10: return {1'($urandom), 11'd1150, 23'h7F_FFFF, 1'b1, 28'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_raw(logic [3:0] fmt);
        logic [63:0] d;
        if (fmt == FMT_F64)
            return pick_double();
        if (fmt == FMT_F32) begin
            d = pick_double();
            case ($urandom_range(0, 3))
                0: return {$urandom, 32'h7F80_0000 | $urandom_range(0, 3)};
                1: return {$urandom, 1'($urandom), 8'd0, 23'($urandom)};
                default: return {$urandom, d[63], d[59:52], d[51:29]};
            endcase
        end
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic logic [63:0] pick_stride();
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000;
            1: return 64'h7FFF_FFFF;
            2: return 64'hFFFF_FFFF;
            default: return {32'($urandom), $urandom};
        endcase
    endfunction

    initial begin
        t_in w;
        logic [3:0] fmt;
        int burst;
        int n;
        sb.reset_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: every format, extremes of the element, start flag both ways
        for (int f = 0; f <= 12; f++) begin
            if (f == 11)
                continue;
            write_reg(REG_ELEMENT_FORMAT, 64'(f));
            w.start_volume = 1'b0;
            w.raw_element = '1;
            send(w);
            w.start_volume = 1'b1;
            w.raw_element = (f == FMT_F32) ? 64'h7FC0_0001 :
                            (f == FMT_F64) ? 64'h8000_0000_0000_0001 :
                            64'h8000_0000_0000_0080;
            send(w);
            idle_gap(1);
            wait_idle();
        end

        while (n < 800) begin
            wait_idle();
            settings++;
            write_reg(REG_ELEMENT_FORMAT, 64'($urandom_range(0, 15)));
            write_reg(REG_SCALE_BITS, pick_double());
            write_reg(REG_OFFSET_BITS, ($urandom_range(0, 2) == 0) ? 64'd0 : pick_double());
            write_reg(REG_ROW_LENGTH, {$urandom, $urandom} & 64'hFFFF_0000 | pick_len());
            write_reg(REG_ROWS_PER_SLICE, {$urandom, 16'($urandom), pick_len()});
            write_reg(REG_STRIDE_X, pick_stride());
            write_reg(REG_STRIDE_Y, pick_stride());
            write_reg(REG_STRIDE_Z, pick_stride());
            fmt = sb.cfg.element_format;
            for (int k = $urandom_range(20, 90); k > 0; k--) begin
                w.raw_element = pick_raw(fmt);
                w.start_volume = ($urandom_range(0, 24) == 0);
                send(w);
                n++;
                if (burst > 0)
                    burst--;
                else begin
                    burst = $urandom_range(0, 15);
                    if (settings % 4 != 0)
                        idle_gap($urandom_range(1, 6));
                end
            end
            idle_gap(1);
        end
        wait_idle();

        $display("%0d words checked over %0d random register settings plus directed formats",
                 sb.checked, settings);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASSED: all results match");
        else begin
            $display("%0d mismatches", sb.errors);
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- raw_voxel_rescale_strided.f -----
sv/rvr_pkg.sv
sv/rvr_nrm.sv
sv/rvr_fifo.sv
sv/rvr_front.sv
sv/rvr_back.sv
sv/raw_voxel_rescale_strided.sv
tb/testbench.sv
